/* src/jsu_pkg.sv */
package jsu_pkg;

    // Input command codes
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_ESCAPE       = 2'd1;
    localparam logic [1:0] ERR_UNICODE      = 2'd2;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd3;

    // Code point width: a joined surrogate pair stays below 0x112000
    localparam int CP_W = 21;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
        logic       last;
    } out_word_t;

    // One decoded input: an optional UTF-8 sequence, then an optional single word
    typedef struct packed {
        logic            cp_en;
        logic [CP_W-1:0] cp;
        logic            tail_en;
        logic [7:0]      tail_byte;
        logic [1:0]      tail_kind;
        logic [1:0]      tail_code;
    } job_t;

endpackage

/* src/json_string_unescape_utf8.sv */
// JSON string body decoder.
// Input channel (s_valid/s_ready/s_data): one word per byte of a string body
// after the opening quote, with a command: string byte, end of text, or start
// of a new string. Output channel (m_valid/m_ready/m_data): decoded bytes,
// then a final word (string closed or an error code) with last set on the
// final word that each input word causes.
// An input word yields zero to four output words: plain bytes and simple
// escapes one, a \u escape one to four UTF-8 bytes, a flushed lone high
// surrogate three bytes plus whatever the next byte yields.
// The front end takes one input word per cycle while the job queue has room;
// the back end sends one output word per cycle while the receiver is ready.
// An accepted word's job is written into the queue, and its first output word
// is then registered in the output register. The queue holds QUEUE_DEPTH decoded
// jobs; when the receiver stalls, the output register holds its word, the queue
// fills, and s_ready drops. Reset empties the queue and the output register and
// returns the decoder to idle, where bytes give no output until a start command.
module json_string_unescape_utf8 import jsu_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t head;
    logic empty;

    assign s_ready = !full;

    jsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_valid && s_ready),
        .in_word (s_data),
        .push    (push),
        .job     (push_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    jsu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* src/jsu_front.sv */
module jsu_front import jsu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     accept,
    input  in_word_t in_word,
    output logic     push,
    output job_t     job
);

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_TEXT    = 6'b000010,
        PH_ESC     = 6'b000100,
        PH_HEX     = 6'b001000,
        PH_HELD    = 6'b010000,
        PH_HELD_BS = 6'b100000
    } phase_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U = 8'h75;

    // Hex digit value with a valid flag on top
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // Simple escape letter to byte, valid flag on top
    function automatic logic [8:0] esc_map(input logic [7:0] e);
        logic [8:0] r;
        r = 9'd0;
        case (e)
            8'h22: r = {1'b1, 8'h22};
            8'h5C: r = {1'b1, 8'h5C};
            8'h2F: r = {1'b1, 8'h2F};
            8'h62: r = {1'b1, 8'h08};
            8'h66: r = {1'b1, 8'h0C};
            8'h6E: r = {1'b1, 8'h0A};
            8'h72: r = {1'b1, 8'h0D};
            8'h74: r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] accum_reg, accum_next;
    logic [15:0] high_reg, high_next;
    logic        low_reg, low_next;

    logic [7:0]      b;
    logic [4:0]      hex;
    logic [8:0]      esc;
    logic [15:0]     accum_shift;
    logic [CP_W-1:0] pair_cp;

    assign b           = in_word.in_byte;
    assign hex         = hex_value(b);
    assign esc         = esc_map(b);
    assign accum_shift = {accum_reg[11:0], hex[3:0]};
    assign pair_cp     = CP_W'(21'h10000) + {1'b0, high_reg[9:0], 10'd0}
                         + {5'd0, accum_shift} - CP_W'(21'h0DC00);

    // Classify the word and build the job for the back end
    always_comb begin
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        accum_next   = accum_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        push         = 1'b0;
        job          = '0;
        if (accept) begin
            unique case (in_word.cmd)
                CMD_START: begin
                    phase_next   = PH_TEXT;
                    hex_cnt_next = 2'd0;
                    accum_next   = 16'd0;
                    high_next    = 16'd0;
                    low_next     = 1'b0;
                end
                CMD_END: begin
                    if (phase_reg != PH_IDLE) begin
                        push          = 1'b1;
                        phase_next    = PH_IDLE;
                        job.tail_en   = 1'b1;
                        job.tail_kind = KIND_ERROR;
                        job.tail_code = (phase_reg == PH_HEX) ? ERR_UNICODE
                                                               : ERR_UNTERMINATED;
                        if (phase_reg == PH_HELD || phase_reg == PH_HELD_BS) begin
                            job.cp_en = 1'b1;
                            job.cp    = {5'd0, high_reg};
                        end
                    end
                end
                CMD_BYTE: begin
                    unique case (phase_reg)
                        PH_TEXT, PH_HELD: begin
                            // flush a held high surrogate unless a backslash follows
                            if (phase_reg == PH_HELD && b == CH_BSLASH) begin
                                phase_next = PH_HELD_BS;
                            end else begin
                                if (phase_reg == PH_HELD) begin
                                    push      = 1'b1;
                                    job.cp_en = 1'b1;
                                    job.cp    = {5'd0, high_reg};
                                end
                                if (b == CH_QUOTE) begin
                                    push          = 1'b1;
                                    phase_next    = PH_IDLE;
                                    job.tail_en   = 1'b1;
                                    job.tail_kind = KIND_CLOSED;
                                end else if (b == CH_BSLASH) begin
                                    phase_next = PH_ESC;
                                end else begin
                                    push          = 1'b1;
                                    phase_next    = PH_TEXT;
                                    job.tail_en   = 1'b1;
                                    job.tail_byte = b;
                                end
                            end
                        end
                        PH_ESC, PH_HELD_BS: begin
                            if (b == CH_U) begin
                                phase_next   = PH_HEX;
                                hex_cnt_next = 2'd0;
                                accum_next   = 16'd0;
                                low_next     = (phase_reg == PH_HELD_BS);
                            end else begin
                                push        = 1'b1;
                                job.tail_en = 1'b1;
                                if (phase_reg == PH_HELD_BS) begin
                                    job.cp_en = 1'b1;
                                    job.cp    = {5'd0, high_reg};
                                end
                                if (esc[8]) begin
                                    phase_next    = PH_TEXT;
                                    job.tail_byte = esc[7:0];
                                end else begin
                                    phase_next    = PH_IDLE;
                                    job.tail_kind = KIND_ERROR;
                                    job.tail_code = ERR_ESCAPE;
                                end
                            end
                        end
                        PH_HEX: begin
                            if (!hex[4]) begin
                                push          = 1'b1;
                                phase_next    = PH_IDLE;
                                job.tail_en   = 1'b1;
                                job.tail_kind = KIND_ERROR;
                                job.tail_code = ERR_UNICODE;
                            end else begin
                                accum_next = accum_shift;
                                if (hex_cnt_reg != 2'd3) begin
                                    hex_cnt_next = hex_cnt_reg + 2'd1;
                                end else begin
                                    hex_cnt_next = 2'd0;
                                    if (low_reg) begin
                                        low_next   = 1'b0;
                                        push       = 1'b1;
                                        phase_next = PH_TEXT;
                                        job.cp_en  = 1'b1;
                                        job.cp     = pair_cp;
                                    end else if (accum_shift >= 16'hD800 &&
                                                 accum_shift <= 16'hDBFF) begin
                                        high_next  = accum_shift;
                                        phase_next = PH_HELD;
                                    end else begin
                                        push       = 1'b1;
                                        phase_next = PH_TEXT;
                                        job.cp_en  = 1'b1;
                                        job.cp     = {5'd0, accum_shift};
                                    end
                                end
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            hex_cnt_reg <= 2'd0;
            accum_reg   <= 16'd0;
            high_reg    <= 16'd0;
            low_reg     <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            accum_reg   <= accum_next;
            high_reg    <= high_next;
            low_reg     <= low_next;
        end
    end

    // A job always carries at least one word
    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (job.cp_en || job.tail_en))
        else $error("front pushed an empty job");

    // Only a surrogate can be held
    a_high_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HELD || phase_reg == PH_HELD_BS) |->
            (high_reg >= 16'hD800 && high_reg <= 16'hDBFF))
        else $error("held unit is not a high surrogate");

endmodule

/* src/jsu_queue.sv */
module jsu_queue import jsu_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count over depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

/* src/jsu_back.sv */
module jsu_back import jsu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  job_t      head,
    input  logic      empty,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    // UTF-8 sequence length of a code point
    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp < CP_W'(21'h80)) begin
            n = 3'd1;
        end else if (cp < CP_W'(21'h800)) begin
            n = 3'd2;
        end else if (cp < CP_W'(21'h10000)) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    // Byte at position idx of the UTF-8 sequence
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [2:0] n,
                                             input logic [1:0] idx);
        logic [7:0] r;
        r = 8'h00;
        case (n)
            3'd1: r = cp[7:0];
            3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_word_t  m_data_reg, m_data_next;

    logic [2:0] len;
    logic [2:0] total;
    logic       in_seq;
    logic       is_last;
    logic       load;

    assign len     = utf8_len(head.cp);
    assign total   = (head.cp_en ? len : 3'd0) + {2'd0, head.tail_en};
    assign in_seq  = head.cp_en && ({1'b0, idx_reg} < len);
    assign is_last = ({1'b0, idx_reg} == total - 3'd1);
    assign load    = !empty && (!m_valid_reg || m_ready);
    assign pop     = load && is_last;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Pick the next word of the job at the queue head
    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            idx_next     = is_last ? 2'd0 : idx_reg + 2'd1;
            if (in_seq) begin
                m_data_next.out_byte   = utf8_byte(head.cp, len, idx_reg);
                m_data_next.kind       = KIND_BYTE;
                m_data_next.error_code = ERR_NONE;
            end else begin
                m_data_next.out_byte   = head.tail_byte;
                m_data_next.kind       = head.tail_kind;
                m_data_next.error_code = head.tail_code;
            end
            m_data_next.last = is_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the output word
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_mid_job_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 2'd0) |-> !empty)
        else $error("job index set with no job at head");

    a_byte_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_BYTE) |-> m_data_reg.error_code == ERR_NONE)
        else $error("decoded byte carries an error code");

    a_index_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> ({1'b0, idx_reg} < total))
        else $error("job index past job end");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import jsu_pkg::*;

    // Command code the block must ignore
    localparam logic [1:0] CMD_RSVD = 2'd3;

    // String syntax bytes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam int RAND_ITEMS   = 430;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_NS     = 400000;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TEXT, ST_ESC, ST_HEX, ST_HELD, ST_HELD_BS
    } dec_state_t;

    // How a stimulus word's results are known
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} rowchk_t;

    typedef struct packed {
        in_word_t  w;
        rowchk_t   chk;
        out_word_t res;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // Tags that travel with the word on s_data
    rowchk_t   cur_chk;
    out_word_t cur_res;

    // Decoder model state
    dec_state_t  dec_state = ST_IDLE;
    logic [1:0]  digits    = '0;
    logic [15:0] accum     = '0;
    logic [15:0] held_unit = '0;
    logic        low_pending = 1'b0;

    out_word_t step_words[$];
    out_word_t decoded_q[$];
    dir_row_t  dir_rows[$];

    int n_fail     = 0;
    int live_items = 0;
    int burst_left = 0;
    int rx_left    = 0;
    bit str_open;

    always #1 aclk = ~aclk;

    json_string_unescape_utf8 u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ---------------------------------------------------------------
    // Decoder model
    // ---------------------------------------------------------------
    function automatic void emit(logic [7:0] b, logic [1:0] k, logic [1:0] c);
        out_word_t w;
        w.out_byte   = b;
        w.kind       = k;
        w.error_code = c;
        w.last       = 1'b0;
        step_words = {step_words, w};
    endfunction

    function automatic void emit_utf8(logic [31:0] cp);
        logic [31:0] s6, s12, s18;
        s6  = cp >> 6;
        s12 = cp >> 12;
        s18 = cp >> 18;
        if (cp < 32'h80) begin
            emit(cp[7:0], KIND_BYTE, ERR_NONE);
        end else if (cp < 32'h800) begin
            emit(8'hC0 | s6[7:0], KIND_BYTE, ERR_NONE);
            emit(8'h80 | {2'b00, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end else if (cp < 32'h10000) begin
            emit(8'hE0 | s12[7:0], KIND_BYTE, ERR_NONE);
            emit(8'h80 | {2'b00, s6[5:0]}, KIND_BYTE, ERR_NONE);
            emit(8'h80 | {2'b00, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end else begin
            emit(8'hF0 | s18[7:0], KIND_BYTE, ERR_NONE);
            emit(8'h80 | {2'b00, s12[5:0]}, KIND_BYTE, ERR_NONE);
            emit(8'h80 | {2'b00, s6[5:0]}, KIND_BYTE, ERR_NONE);
            emit(8'h80 | {2'b00, cp[5:0]}, KIND_BYTE, ERR_NONE);
        end
    endfunction

    function automatic void end_string(logic [1:0] k, logic [1:0] c);
        emit(8'h00, k, c);
        dec_state = ST_IDLE;
    endfunction

    function automatic int hex_val(logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h57);
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h37);
        return -1;
    endfunction

    function automatic void take_text(logic [7:0] b);
        if (b == CH_QUOTE) end_string(KIND_CLOSED, ERR_NONE);
        else if (b == CH_BSLASH) dec_state = ST_ESC;
        else emit(b, KIND_BYTE, ERR_NONE);
    endfunction

    function automatic void take_escape(logic [7:0] e);
        dec_state = ST_TEXT;
        case (e)
            CH_QUOTE, CH_BSLASH, CH_SLASH: emit(e, KIND_BYTE, ERR_NONE);
            CH_B: emit(8'h08, KIND_BYTE, ERR_NONE);
            CH_F: emit(8'h0C, KIND_BYTE, ERR_NONE);
            CH_N: emit(8'h0A, KIND_BYTE, ERR_NONE);
            CH_R: emit(8'h0D, KIND_BYTE, ERR_NONE);
            CH_T: emit(8'h09, KIND_BYTE, ERR_NONE);
            CH_U: begin
                dec_state   = ST_HEX;
                digits      = '0;
                accum       = '0;
                low_pending = 1'b0;
            end
            default: end_string(KIND_ERROR, ERR_ESCAPE);
        endcase
    endfunction

    function automatic void take_hex(logic [7:0] b);
        int v;
        logic [31:0] h32, a32;
        v = hex_val(b);
        if (v < 0) begin
            end_string(KIND_ERROR, ERR_UNICODE);
            return;
        end
        accum = {accum[11:0], v[3:0]};
        if (digits < 2'd3) begin
            digits = digits + 2'd1;
            return;
        end
        digits = '0;
        h32 = {16'h0, held_unit};
        a32 = {16'h0, accum};
        if (low_pending) begin
            // join the pair with plain 32-bit wraparound, low unit unchecked
            low_pending = 1'b0;
            emit_utf8(32'h10000 + ((h32 - 32'hD800) << 10) + (a32 - 32'hDC00));
            dec_state = ST_TEXT;
        end else if (accum >= 16'hD800 && accum <= 16'hDBFF) begin
            held_unit = accum;
            dec_state = ST_HELD;
        end else begin
            emit_utf8(a32);
            dec_state = ST_TEXT;
        end
    endfunction

    // Advance the model by one accepted word; results land in step_words
    function automatic void decode_word(in_word_t w);
        step_words.delete();
        if (w.cmd == CMD_START) begin
            dec_state   = ST_TEXT;
            digits      = '0;
            accum       = '0;
            held_unit   = '0;
            low_pending = 1'b0;
            return;
        end
        if (w.cmd == CMD_RSVD || dec_state == ST_IDLE) return;
        if (w.cmd == CMD_END) begin
            case (dec_state)
                ST_HEX: end_string(KIND_ERROR, ERR_UNICODE);
                ST_HELD, ST_HELD_BS: begin
                    emit_utf8({16'h0, held_unit});
                    end_string(KIND_ERROR, ERR_UNTERMINATED);
                end
                default: end_string(KIND_ERROR, ERR_UNTERMINATED);
            endcase
        end else begin
            case (dec_state)
                ST_TEXT: take_text(w.in_byte);
                ST_ESC:  take_escape(w.in_byte);
                ST_HEX:  take_hex(w.in_byte);
                ST_HELD: begin
                    if (w.in_byte == CH_BSLASH) begin
                        dec_state = ST_HELD_BS;
                    end else begin
                        emit_utf8({16'h0, held_unit});
                        dec_state = ST_TEXT;
                        take_text(w.in_byte);
                    end
                end
                ST_HELD_BS: begin
                    if (w.in_byte == CH_U) begin
                        dec_state   = ST_HEX;
                        digits      = '0;
                        accum       = '0;
                        low_pending = 1'b1;
                    end else begin
                        emit_utf8({16'h0, held_unit});
                        take_escape(w.in_byte);
                    end
                end
                default: dec_state = ST_IDLE;
            endcase
        end
        // flag the final word of this input
        if (step_words.size() > 0) begin
            step_words[step_words.size() - 1].last = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Predict on input acceptance, then check the output word
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_word(s_data);
                case (cur_chk)
                    CHK_PREDICT: foreach (step_words[i]) decoded_q = {decoded_q, step_words[i]};
                    CHK_ONE:     decoded_q = {decoded_q, cur_res};
                    default:     ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: word with nothing expected: expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        n_fail++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.out_byte, m_data.out_byte);
                    end
                    if (m_data.kind !== want.kind) begin
                        n_fail++;
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, m_data.kind);
                    end
                    if (m_data.error_code !== want.error_code) begin
                        n_fail++;
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.error_code, m_data.error_code);
                    end
                    if (m_data.last !== want.last) begin
                        n_fail++;
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, m_data.last);
                    end
                end
            end
        end
    end

    // Receiver: alternate stall and ready stretches, some of them long
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            if (m_ready) begin
                m_ready <= 1'b0;
                rx_left <= $urandom_range(1, 6);
            end else begin
                m_ready <= 1'b1;
                rx_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            end
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    // Enter and leave at a falling edge; hold the word until accepted
    task automatic send_word(logic [1:0] c, logic [7:0] b, rowchk_t chk, out_word_t res);
        in_word_t w;
        w.cmd     = c;
        w.in_byte = b;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        cur_chk <= chk;
        cur_res <= res;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic send_live(logic [1:0] c, logic [7:0] b);
        live_items++;
        send_word(c, b, CHK_PREDICT, '0);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_live(CMD_BYTE, b);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'd0, v};
        return (($urandom_range(0, 1) == 1) ? 8'h57 : 8'h37) + {4'd0, v};
    endfunction

    function automatic bit is_escape_letter(logic [7:0] b);
        return b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
               b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U;
    endfunction

    function automatic logic [7:0] rnd_plain();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
        return b;
    endfunction

    function automatic logic [7:0] rnd_simple_escape();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [7:0] rnd_bad_escape();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
        return b;
    endfunction

    function automatic logic [7:0] rnd_bad_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
        return b;
    endfunction

    function automatic logic [15:0] rnd_high();
        return 16'hD800 + 16'($urandom_range(0, 16'h3FF));
    endfunction

    task automatic send_unit(logic [15:0] u);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--) send_byte(hex_char(u[i*4 +: 4]));
    endtask

    // Open a \u and give it only part of its digits
    task automatic send_partial_unit();
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15))));
    endtask

    task automatic gen_segment();
        int p;
        logic [15:0] u;
        p = $urandom_range(0, 99);
        if (p < 35) begin
            send_byte(rnd_plain());
        end else if (p < 50) begin
            send_byte(CH_BSLASH);
            send_byte(rnd_simple_escape());
        end else if (p < 65) begin
            case ($urandom_range(0, 3))
                0: u = 16'($urandom_range(0, 16'h7F));
                1: u = 16'($urandom_range(16'h80, 16'h7FF));
                2: u = 16'($urandom_range(16'hDC00, 16'hFFFF));
                default: u = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_unit(u);
        end else if (p < 80) begin
            // surrogate pair, sometimes with a low unit out of range
            send_unit(rnd_high());
            if ($urandom_range(0, 9) < 7) send_unit(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
            else send_unit(16'($urandom_range(0, 16'hFFFF)));
        end else if (p < 88) begin
            // lone high surrogate, flushed by what follows
            send_unit(rnd_high());
            case ($urandom_range(0, 3))
                0: send_byte(rnd_plain());
                1: begin
                    send_byte(CH_BSLASH);
                    send_byte(rnd_simple_escape());
                end
                2: begin
                    send_byte(CH_BSLASH);
                    send_byte(rnd_bad_escape());
                    str_open = 0;
                end
                default: ;
            endcase
        end else if (p < 93) begin
            send_byte(CH_BSLASH);
            send_byte(rnd_bad_escape());
            str_open = 0;
        end else if (p < 98) begin
            if ($urandom_range(0, 1) == 1) send_unit(rnd_high());
            send_partial_unit();
            send_byte(rnd_bad_hex());
            str_open = 0;
        end else begin
            send_word(CMD_RSVD, 8'($urandom_range(0, 255)), CHK_PREDICT, '0);
        end
    endtask

    task automatic gen_ending();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) begin
            send_byte(CH_QUOTE);
        end else if (p < 77) begin
            send_live(CMD_END, 8'($urandom_range(0, 255)));
        end else if (p < 82) begin
            send_byte(CH_BSLASH);
            send_live(CMD_END, 8'($urandom_range(0, 255)));
        end else if (p < 87) begin
            send_partial_unit();
            send_live(CMD_END, 8'($urandom_range(0, 255)));
        end else if (p < 91) begin
            send_unit(rnd_high());
            send_live(CMD_END, 8'($urandom_range(0, 255)));
        end else if (p < 94) begin
            send_unit(rnd_high());
            send_byte(CH_BSLASH);
            send_live(CMD_END, 8'($urandom_range(0, 255)));
        end else if (p < 97) begin
            send_unit(rnd_high());
            send_partial_unit();
            send_live(CMD_END, 8'($urandom_range(0, 255)));
        end
        // otherwise leave the string open for the next start to drop
    endtask

    task automatic gen_string();
        int nseg;
        // stray words between strings
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: send_word(CMD_BYTE, 8'($urandom_range(0, 255)), CHK_PREDICT, '0);
                    1: send_word(CMD_END, 8'($urandom_range(0, 255)), CHK_PREDICT, '0);
                    default: send_word(CMD_RSVD, 8'($urandom_range(0, 255)), CHK_PREDICT, '0);
                endcase
            end
        end
        send_live(CMD_START, 8'($urandom_range(0, 255)));
        str_open = 1;
        nseg = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        for (int k = 0; k < nseg && str_open; k++) gen_segment();
        if (str_open) gen_ending();
    endtask

    function automatic dir_row_t mk(logic [1:0] c, logic [7:0] b, rowchk_t chk,
                                    logic [7:0] ob, logic [1:0] k, logic [1:0] e);
        dir_row_t r;
        r.w.cmd          = c;
        r.w.in_byte      = b;
        r.chk            = chk;
        r.res.out_byte   = ob;
        r.res.kind       = k;
        r.res.error_code = e;
        r.res.last       = 1'b1;
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(dir_row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        cur_chk = CHK_PREDICT;
        cur_res = '0;

        // directed words: idle handling, extremes, each error, a flushed surrogate
        add_row(mk(CMD_BYTE,  8'h41,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_END,   8'h00,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_RSVD,  8'h41,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_START, 8'h00,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'h00,     CHK_ONE,  8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'hFF,     CHK_ONE,  8'hFF, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_RSVD,  CH_BSLASH, CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_BSLASH, CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_END,   8'hFF,     CHK_ONE,  8'h00, KIND_ERROR, ERR_UNTERMINATED));
        add_row(mk(CMD_START, 8'hFF,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_BSLASH, CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_U,      CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'h44,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'h38,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'h30,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'h30,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_BSLASH, CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_N,   CHK_PREDICT, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_BSLASH, CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_U,      CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'h67,     CHK_ONE,  8'h00, KIND_ERROR, ERR_UNICODE));
        add_row(mk(CMD_START, 8'h00,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_BSLASH, CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'h71,     CHK_ONE,  8'h00, KIND_ERROR, ERR_ESCAPE));
        add_row(mk(CMD_START, 8'h00,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_BSLASH, CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_U,      CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  8'h31,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_END,   8'h00,     CHK_ONE,  8'h00, KIND_ERROR, ERR_UNICODE));
        add_row(mk(CMD_START, 8'h00,     CHK_NONE, 8'h00, KIND_BYTE, ERR_NONE));
        add_row(mk(CMD_BYTE,  CH_QUOTE,  CHK_ONE,  8'h00, KIND_CLOSED, ERR_NONE));

        // hold reset, then release it at a falling edge
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].w.cmd, dir_rows[i].w.in_byte, dir_rows[i].chk,
                      dir_rows[i].res);
        end

        while (live_items < RAND_ITEMS) gen_string();

        // drop valid and drain
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_fail == 0 && decoded_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
